// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication that starts with an output request on display.
`define ASSERT_OUT(lbl, prop, msg) \
	`ASSERT_CLK(lbl, out_valid |-> (prop), msg)

`endif

// ===== hdl/rxars_pkg.sv =====
package rxars_pkg;

	localparam int TIME_W  = 32;
	localparam int CFG_W   = 24;
	localparam int TALLY_W = 32;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic [CFG_W-1:0] HOLD_RST    = CFG_W'(10);
	localparam logic [CFG_W-1:0] DONE_TO_RST = CFG_W'(250000);
	localparam logic [CFG_W-1:0] POST_TO_RST = CFG_W'(1000);
	localparam logic [CFG_W-1:0] SETTLE_RST  = CFG_W'(250000);

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	typedef enum logic [2:0] {
		ST_ALIGNED   = 3'd0,
		ST_APPLY     = 3'd1,
		ST_HOLD      = 3'd2,
		ST_AWAIT     = 3'd3,
		ST_POSTRESET = 3'd4,
		ST_SETTLE    = 3'd5
	} seq_state_t;

	typedef enum logic [1:0] {
		REG_HOLD    = 2'd0,
		REG_DONE_TO = 2'd1,
		REG_POST_TO = 2'd2,
		REG_SETTLE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] hold_time_us;
		logic [CFG_W-1:0] reset_done_timeout_us;
		logic [CFG_W-1:0] post_reset_timeout_us;
		logic [CFG_W-1:0] settle_time_us;
	} cfg_t;

	typedef struct packed {
		logic               is_aligned;
		logic               soft_reset_drive;
		logic [2:0]         state_code;
		logic [TALLY_W-1:0] resets_tried;
	} result_t;

endpackage

// ===== hdl/rxars_cfg.sv =====
module rxars_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rxars_pkg::ADDR_W-1:0]   paddr,
	input  logic [rxars_pkg::DATA_W-1:0]   pwdata,
	output logic [rxars_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	output rxars_pkg::cfg_t                cfg
);

	rxars_pkg::cfg_t       cfg_q;
	rxars_pkg::reg_idx_t   idx;
	logic                  wr_en;
	logic [rxars_pkg::CFG_W-1:0] rd_val;

	assign idx    = rxars_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time_us          <= rxars_pkg::HOLD_RST;
			cfg_q.reset_done_timeout_us <= rxars_pkg::DONE_TO_RST;
			cfg_q.post_reset_timeout_us <= rxars_pkg::POST_TO_RST;
			cfg_q.settle_time_us        <= rxars_pkg::SETTLE_RST;
		end else if (wr_en) begin
			case (idx)
				rxars_pkg::REG_HOLD:    cfg_q.hold_time_us <= pwdata[rxars_pkg::CFG_W-1:0];
				rxars_pkg::REG_DONE_TO: cfg_q.reset_done_timeout_us <= pwdata[rxars_pkg::CFG_W-1:0];
				rxars_pkg::REG_POST_TO: cfg_q.post_reset_timeout_us <= pwdata[rxars_pkg::CFG_W-1:0];
				rxars_pkg::REG_SETTLE:  cfg_q.settle_time_us <= pwdata[rxars_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rxars_pkg::REG_HOLD:    rd_val = cfg_q.hold_time_us;
			rxars_pkg::REG_DONE_TO: rd_val = cfg_q.reset_done_timeout_us;
			rxars_pkg::REG_POST_TO: rd_val = cfg_q.post_reset_timeout_us;
			rxars_pkg::REG_SETTLE:  rd_val = cfg_q.settle_time_us;
			default:                rd_val = '0;
		endcase
	end

	assign prdata = {{(rxars_pkg::DATA_W-rxars_pkg::CFG_W){1'b0}}, rd_val};

endmodule

// ===== hdl/rxars_core.sv =====
module rxars_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [rxars_pkg::TIME_W-1:0]  now_us,
	input  logic                          rx_aligned,
	input  logic                          rx_reset_done,
	input  rxars_pkg::cfg_t               cfg,
	output rxars_pkg::result_t            result
);

	rxars_pkg::seq_state_t state_q, state_d;
	logic [rxars_pkg::TIME_W-1:0]  entered_q, entered_d;
	logic [rxars_pkg::TALLY_W-1:0] tally_q, tally_d;
	logic                          srst_q, srst_d;
	logic [rxars_pkg::TIME_W-1:0]  elapsed;
	logic [rxars_pkg::CFG_W-1:0]   limit;
	logic                          timeout;

	// One wrap-around subtract and one compare, limit picked by state
	always_comb begin
		case (state_q)
			rxars_pkg::ST_HOLD:      limit = cfg.hold_time_us;
			rxars_pkg::ST_AWAIT:     limit = cfg.reset_done_timeout_us;
			rxars_pkg::ST_POSTRESET: limit = cfg.post_reset_timeout_us;
			rxars_pkg::ST_SETTLE:    limit = cfg.settle_time_us;
			default:                 limit = '0;
		endcase
	end

	assign elapsed = now_us - entered_q;
	assign timeout = elapsed > {{(rxars_pkg::TIME_W-rxars_pkg::CFG_W){1'b0}}, limit};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rxars_pkg::ST_APPLY: state_d = rxars_pkg::ST_HOLD;
			rxars_pkg::ST_HOLD: begin
				if (timeout) state_d = rxars_pkg::ST_AWAIT;
			end
			rxars_pkg::ST_AWAIT: begin
				if (rx_reset_done)  state_d = rxars_pkg::ST_POSTRESET;
				else if (timeout)   state_d = rxars_pkg::ST_APPLY;
			end
			rxars_pkg::ST_POSTRESET: begin
				if (rx_aligned)     state_d = rxars_pkg::ST_SETTLE;
				else if (timeout)   state_d = rxars_pkg::ST_APPLY;
			end
			rxars_pkg::ST_SETTLE: begin
				if (timeout)
					state_d = rx_aligned ? rxars_pkg::ST_ALIGNED : rxars_pkg::ST_APPLY;
			end
			default: state_d = rx_aligned ? rxars_pkg::ST_ALIGNED : rxars_pkg::ST_APPLY;
		endcase
	end

	// Datapath updates
	always_comb begin
		tally_d   = tally_q;
		srst_d    = srst_q;
		entered_d = (state_d != state_q) ? now_us : entered_q;
		case (state_q)
			rxars_pkg::ST_APPLY: begin
				if (tally_q != rxars_pkg::TALLY_MAX) tally_d = tally_q + 1'b1;
				srst_d = 1'b1;
			end
			rxars_pkg::ST_HOLD: begin
				if (timeout) srst_d = 1'b0;
			end
			rxars_pkg::ST_AWAIT, rxars_pkg::ST_POSTRESET, rxars_pkg::ST_SETTLE: ;
			default: tally_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rxars_pkg::ST_ALIGNED;
			entered_q <= '0;
			tally_q   <= '0;
			srst_q    <= 1'b0;
		end else if (step) begin
			state_q   <= state_d;
			entered_q <= entered_d;
			tally_q   <= tally_d;
			srst_q    <= srst_d;
		end
	end

	assign result.is_aligned       = (state_d == rxars_pkg::ST_ALIGNED);
	assign result.soft_reset_drive = srst_d;
	assign result.state_code       = state_d;
	assign result.resets_tried     = tally_d;

endmodule

// ===== hdl/rx_alignment_reset_sequencer.sv =====
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  now_us, rx_aligned, rx_reset_done
// out       source     out_valid/out_stall is_aligned, soft_reset_drive,
//                                         state_code, resets_tried
// cfg       APB slave  psel/penable/pready paddr, pwdata, prdata
//
// One request per clock sustained while out_stall is low; a request waits in
// the input register stage, its result in the result register. The rate is set
// by the state-register feedback: one subtract and one compare per evaluation.
// Reset leaves the sequencer in the aligned state with tally and entry time at
// zero. A stalled output holds its result, and the input stage keeps taking
// requests while the result register is free or drained in the same cycle.
module rx_alignment_reset_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rxars_pkg::TIME_W-1:0]  now_us,
	input  logic                          rx_aligned,
	input  logic                          rx_reset_done,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_aligned,
	output logic                          soft_reset_drive,
	output logic [2:0]                    state_code,
	output logic [rxars_pkg::TALLY_W-1:0] resets_tried,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rxars_pkg::ADDR_W-1:0]  paddr,
	input  logic [rxars_pkg::DATA_W-1:0]  pwdata,
	output logic [rxars_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);

	rxars_pkg::cfg_t    cfg;
	rxars_pkg::result_t result;
	rxars_pkg::result_t res_q;

	// input register stage
	logic                         valid_s1;
	logic [rxars_pkg::TIME_W-1:0] now_us_s1;
	logic                         rx_aligned_s1;
	logic                         rx_reset_done_s1;

	logic out_valid_q;
	logic out_free;
	logic advance;
	logic take_in;

	// The result register frees up when empty or drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	// Move the staged request through the sequencer into the result register
	assign advance  = valid_s1 && out_free;
	// Stall only while a staged request cannot move on
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	rxars_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rxars_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.now_us        (now_us_s1),
		.rx_aligned    (rx_aligned_s1),
		.rx_reset_done (rx_reset_done_s1),
		.cfg           (cfg),
		.result        (result)
	);

	// Stage valid: fill on an accepted request, drop when it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload needs no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			now_us_s1        <= now_us;
			rx_aligned_s1    <= rx_aligned;
			rx_reset_done_s1 <= rx_reset_done;
		end
	end

	// Result valid: set on advance, clear when the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign is_aligned       = res_q.is_aligned;
	assign soft_reset_drive = res_q.soft_reset_drive;
	assign state_code       = res_q.state_code;
	assign resets_tried     = res_q.resets_tried;

endmodule

// ===== hdl/rxars_checker.sv =====
`include "assert_macros.svh"

module rxars_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          is_aligned,
	input logic                          soft_reset_drive,
	input logic [2:0]                    state_code,
	input logic [rxars_pkg::TALLY_W-1:0] resets_tried
);

	// A stalled result stays up unchanged
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(state_code) && $stable(resets_tried), "stalled result changed")

	// Aligned flag matches the reported state
	`ASSERT_OUT(a_aligned_code, is_aligned == (state_code == rxars_pkg::ST_ALIGNED), "aligned flag disagrees with state")

	// Soft reset is driven exactly while holding reset
	`ASSERT_OUT(a_srst_hold, soft_reset_drive == (state_code == rxars_pkg::ST_HOLD), "soft reset level disagrees with state")

	// Holding reset means at least one reset has been counted
	`ASSERT_OUT(a_tally_hold, state_code != rxars_pkg::ST_HOLD || resets_tried != '0, "reset tally zero while holding reset")

endmodule

bind rx_alignment_reset_sequencer rxars_checker u_rxars_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.is_aligned       (is_aligned),
	.soft_reset_drive (soft_reset_drive),
	.state_code       (state_code),
	.resets_tried     (resets_tried)
);
